@@ sv/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, microcode encoding and control store for the record sorter.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int IdW    = 16;
  localparam int ScoreW = 16;
  localparam int TotalW = 17;
  localparam int PcW    = 4;
  localparam int OpW    = 4;
  localparam int CondW  = 4;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] run;
    logic [ScoreW-1:0] bike;
    logic [TotalW-1:0] total;
  } rss_rec_t;

  // read address select
  localparam logic RS_POS  = 1'b0;
  localparam logic RS_SCAN = 1'b1;

  // datapath operations
  localparam logic [OpW-1:0] OP_NONE      = 4'd0;
  localparam logic [OpW-1:0] OP_POS_CLR   = 4'd1;
  localparam logic [OpW-1:0] OP_PASS      = 4'd2;
  localparam logic [OpW-1:0] OP_LOAD_BEST = 4'd3;
  localparam logic [OpW-1:0] OP_SCAN      = 4'd4;
  localparam logic [OpW-1:0] OP_CMP       = 4'd5;
  localparam logic [OpW-1:0] OP_WR_POS    = 4'd6;
  localparam logic [OpW-1:0] OP_WR_BEST   = 4'd7;
  localparam logic [OpW-1:0] OP_SCAN_CLR  = 4'd8;
  localparam logic [OpW-1:0] OP_OUT_LOAD  = 4'd9;
  localparam logic [OpW-1:0] OP_FIN       = 4'd10;

  // jump conditions
  localparam logic [CondW-1:0] C_NONE      = 4'd0;
  localparam logic [CondW-1:0] C_ALWAYS    = 4'd1;
  localparam logic [CondW-1:0] C_ACC_LAST  = 4'd2;
  localparam logic [CondW-1:0] C_FEW       = 4'd3;
  localparam logic [CondW-1:0] C_SCAN_LAST = 4'd4;
  localparam logic [CondW-1:0] C_SCAN_MORE = 4'd5;
  localparam logic [CondW-1:0] C_POS_MORE  = 4'd6;
  localparam logic [CondW-1:0] C_OUT_FREE  = 4'd7;
  localparam logic [CondW-1:0] C_EMIT_MORE = 4'd8;

  // program steps
  localparam logic [PcW-1:0] ST_IDLE      = 4'd0;
  localparam logic [PcW-1:0] ST_SORT_INIT = 4'd1;
  localparam logic [PcW-1:0] ST_PASS      = 4'd2;
  localparam logic [PcW-1:0] ST_LOAD      = 4'd3;
  localparam logic [PcW-1:0] ST_SCAN      = 4'd4;
  localparam logic [PcW-1:0] ST_TAIL      = 4'd5;
  localparam logic [PcW-1:0] ST_SWAP_A    = 4'd6;
  localparam logic [PcW-1:0] ST_SWAP_B    = 4'd7;
  localparam logic [PcW-1:0] ST_EMIT_INIT = 4'd8;
  localparam logic [PcW-1:0] ST_EMIT_RD   = 4'd9;
  localparam logic [PcW-1:0] ST_EMIT_WAIT = 4'd10;
  localparam logic [PcW-1:0] ST_EMIT_LD   = 4'd11;
  localparam logic [PcW-1:0] ST_FIN       = 4'd12;

  typedef struct packed {
    logic             in_rdy;
    logic             rd_en;
    logic             rsel;
    logic [OpW-1:0]   op;
    logic [CondW-1:0] cond;
    logic             hold;    // stay on this step when the jump is not taken
    logic [PcW-1:0]   target;
  } rss_ctrl_t;

  typedef struct packed {
    logic acc_last;
    logic few;
    logic scan_last;
    logic pos_more;
    logic emit_more;
    logic out_free;
  } rss_status_t;

  function automatic rss_ctrl_t rss_cw(input logic in_rdy, input logic rd_en,
                                       input logic rsel, input logic [OpW-1:0] op,
                                       input logic [CondW-1:0] cond, input logic hold,
                                       input logic [PcW-1:0] target);
    rss_ctrl_t cw;
    cw.in_rdy = in_rdy;
    cw.rd_en  = rd_en;
    cw.rsel   = rsel;
    cw.op     = op;
    cw.cond   = cond;
    cw.hold   = hold;
    cw.target = target;
    return cw;
  endfunction

  // control store: one word per step
  function automatic rss_ctrl_t rss_rom(input logic [PcW-1:0] pc);
    rss_ctrl_t cw;
    unique case (pc)
      ST_IDLE:      cw = rss_cw(1'b1, 1'b0, RS_POS,  OP_NONE,      C_ACC_LAST,  1'b1,
                            ST_SORT_INIT);
      ST_SORT_INIT: cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_POS_CLR,   C_FEW,       1'b0,
                            ST_EMIT_INIT);
      ST_PASS:      cw = rss_cw(1'b0, 1'b1, RS_POS,  OP_PASS,      C_NONE,      1'b0,
                            ST_IDLE);
      ST_LOAD:      cw = rss_cw(1'b0, 1'b1, RS_SCAN, OP_LOAD_BEST, C_SCAN_LAST, 1'b0,
                            ST_TAIL);
      ST_SCAN:      cw = rss_cw(1'b0, 1'b1, RS_SCAN, OP_SCAN,      C_SCAN_MORE, 1'b0,
                            ST_SCAN);
      ST_TAIL:      cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_CMP,       C_NONE,      1'b0,
                            ST_IDLE);
      ST_SWAP_A:    cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_WR_POS,    C_NONE,      1'b0,
                            ST_IDLE);
      ST_SWAP_B:    cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_WR_BEST,   C_POS_MORE,  1'b0,
                            ST_PASS);
      ST_EMIT_INIT: cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_SCAN_CLR,  C_NONE,      1'b0,
                            ST_IDLE);
      ST_EMIT_RD:   cw = rss_cw(1'b0, 1'b1, RS_SCAN, OP_NONE,      C_NONE,      1'b0,
                            ST_IDLE);
      ST_EMIT_WAIT: cw = rss_cw(1'b0, 1'b1, RS_SCAN, OP_NONE,      C_OUT_FREE,  1'b1,
                            ST_EMIT_LD);
      ST_EMIT_LD:   cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_OUT_LOAD,  C_EMIT_MORE, 1'b0,
                            ST_EMIT_WAIT);
      ST_FIN:       cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_FIN,       C_ALWAYS,    1'b0,
                            ST_IDLE);
      default:      cw = rss_cw(1'b0, 1'b0, RS_POS,  OP_NONE,      C_ALWAYS,    1'b0,
                            ST_IDLE);
    endcase
    return cw;
  endfunction

endpackage

@@ sv/rss_if.sv @@
// ----------------------------------------------------------------------------
// rss_if
// Valid/ready channels for record items in and sorted record items out.
// ----------------------------------------------------------------------------
interface rss_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] record_id;
  logic [15:0] run_score;
  logic [15:0] bike_score;
  logic        last_record;

  modport source (output valid, record_id, run_score, bike_score, last_record,
                  input ready);
  modport sink (input valid, record_id, run_score, bike_score, last_record,
                output ready);
endinterface

interface rss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [15:0] out_run;
  logic [15:0] out_bike;
  logic [16:0] out_total;
  logic        out_last;
  logic        overflow;

  modport source (output valid, out_id, out_run, out_bike, out_total, out_last, overflow,
                  input ready);
  modport sink (input valid, out_id, out_run, out_bike, out_total, out_last, overflow,
                output ready);
endinterface

@@ sv/rss_seq.sv @@
// ----------------------------------------------------------------------------
// rss_seq
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module rss_seq
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rss_status_t status_i,
  output rss_ctrl_t   ctrl_o
);

  logic [PcW-1:0] pc_r;
  logic [PcW-1:0] pc_nxt;
  rss_ctrl_t      cw;
  logic           take;

  assign cw     = rss_rom(pc_r);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_ACC_LAST:  take = status_i.acc_last;
      C_FEW:       take = status_i.few;
      C_SCAN_LAST: take = status_i.scan_last;
      C_SCAN_MORE: take = !status_i.scan_last;
      C_POS_MORE:  take = status_i.pos_more;
      C_OUT_FREE:  take = status_i.out_free;
      C_EMIT_MORE: take = status_i.emit_more;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (take) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + PcW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ sv/rss_dp.sv @@
// ----------------------------------------------------------------------------
// rss_dp
// Record store, selection sort registers and the output register.
// ----------------------------------------------------------------------------
module rss_dp
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS,
  localparam int AW = $clog2(MAX_RECORDS),
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rss_ctrl_t   ctrl_i,
  input  logic        in_fire_i,
  input  rss_rec_t    in_rec_i,
  input  logic        in_last_i,
  input  logic        out_ready_i,
  output rss_status_t status_o,
  output logic        out_valid_o,
  output rss_rec_t    out_rec_o,
  output logic        out_last_o,
  output logic        out_overflow_o
);

  rss_rec_t mem [MAX_RECORDS];

  logic [CW-1:0] count_r;
  logic          dropped_r;
  logic          out_valid_r;
  logic [AW-1:0] pos_r;
  logic [CW-1:0] scan_r;
  logic [AW-1:0] best_r;
  logic [AW-1:0] rd_idx_r;
  rss_rec_t      best_rec_r;
  rss_rec_t      pos_rec_r;
  rss_rec_t      rdata_r;
  rss_rec_t      out_rec_r;
  logic          out_last_r;
  logic          out_ovf_r;

  logic          full;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rss_rec_t      wr_data;
  logic          smaller;
  logic [CW:0]   count_x;
  logic [CW:0]   scan_x;
  logic [CW:0]   pos_x;

  assign full    = (count_r == CW'(MAX_RECORDS));
  assign rd_addr = (ctrl_i.rsel == RS_SCAN) ? scan_r[AW-1:0] : pos_r;
  assign smaller = (rdata_r.total < best_rec_r.total);
  assign count_x = (CW+1)'(count_r);
  assign scan_x  = (CW+1)'(scan_r);
  assign pos_x   = (CW+1)'(pos_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_rec_i;
    priority if (in_fire_i && !full) begin
      wr_en = 1'b1;
    end else if (ctrl_i.op == OP_WR_POS) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = best_rec_r;
    end else if (ctrl_i.op == OP_WR_BEST) begin
      wr_en   = 1'b1;
      wr_addr = best_r;
      wr_data = pos_rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_r  <= mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire_i) begin
        if (!full) begin
          count_r <= count_r + CW'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (ctrl_i.op == OP_FIN) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
      if (ctrl_i.op == OP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl_i.op)
      OP_POS_CLR: begin
        pos_r <= '0;
      end
      OP_PASS: begin
        scan_r <= CW'(pos_r) + CW'(1);
      end
      OP_LOAD_BEST: begin
        best_r     <= pos_r;
        best_rec_r <= rdata_r;
        pos_rec_r  <= rdata_r;
        scan_r     <= scan_r + CW'(1);
      end
      OP_SCAN: begin
        if (smaller) begin
          best_r     <= rd_idx_r;
          best_rec_r <= rdata_r;
        end
        scan_r <= scan_r + CW'(1);
      end
      OP_CMP: begin
        if (smaller) begin
          best_r     <= rd_idx_r;
          best_rec_r <= rdata_r;
        end
      end
      OP_WR_BEST: begin
        pos_r <= pos_r + AW'(1);
      end
      OP_SCAN_CLR: begin
        scan_r <= '0;
      end
      OP_OUT_LOAD: begin
        out_rec_r  <= rdata_r;
        out_last_r <= !status_o.emit_more;
        out_ovf_r  <= dropped_r;
        scan_r     <= scan_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  assign status_o.acc_last  = in_fire_i && in_last_i;
  assign status_o.few       = (count_x < (CW+1)'(2));
  assign status_o.scan_last = ((scan_x + (CW+1)'(1)) >= count_x);
  assign status_o.pos_more  = ((pos_x + (CW+1)'(2)) < count_x);
  assign status_o.emit_more = ((scan_x + (CW+1)'(1)) != count_x);
  assign status_o.out_free  = !out_valid_r || out_ready_i;

  assign out_valid_o    = out_valid_r;
  assign out_rec_o      = out_rec_r;
  assign out_last_o     = out_last_r;
  assign out_overflow_o = out_ovf_r;

endmodule

@@ sv/record_selection_sorter_top.sv @@
// ----------------------------------------------------------------------------
// record_selection_sorter_top
// Collects a set of records, sorts them by total score, emits them in order.
// ----------------------------------------------------------------------------
// in_ch takes one record item per cycle while the block is collecting. Each
// record gets total = run + bike and is written to the record store; records
// beyond MAX_RECORDS are dropped and flag overflow on every item of the set.
// An item with last_record set closes the set: in_ch.ready drops while a
// microcoded selection sort runs over the store and the set is sent on out_ch.
// Each sort pass scans the remaining records for the smallest total, bound
// by the single store read port.
// Emission then reads the store in order; the last item carries out_last.
// A stalled out_ch holds its output register and the sequencer waits on it;
// the last item of a set may still sit there while the next set loads.
// Synchronous active-low reset returns to collecting with an empty set and
// no output pending; store contents are not cleared.
// ----------------------------------------------------------------------------
module record_selection_sorter_top
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rss_in_if.sink    in_ch,
  rss_out_if.source out_ch
);

  rss_ctrl_t   ctrl;
  rss_status_t status;
  rss_rec_t    in_rec;
  rss_rec_t    out_rec;
  logic        in_fire;

  assign in_ch.ready  = ctrl.in_rdy;
  assign in_fire      = in_ch.valid && ctrl.in_rdy;

  assign in_rec.id    = in_ch.record_id;
  assign in_rec.run   = in_ch.run_score;
  assign in_rec.bike  = in_ch.bike_score;
  assign in_rec.total = TotalW'(in_ch.run_score) + TotalW'(in_ch.bike_score);

  rss_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  rss_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl_i         (ctrl),
    .in_fire_i      (in_fire),
    .in_rec_i       (in_rec),
    .in_last_i      (in_ch.last_record),
    .out_ready_i    (out_ch.ready),
    .status_o       (status),
    .out_valid_o    (out_ch.valid),
    .out_rec_o      (out_rec),
    .out_last_o     (out_ch.out_last),
    .out_overflow_o (out_ch.overflow)
  );

  assign out_ch.out_id    = out_rec.id;
  assign out_ch.out_run   = out_rec.run;
  assign out_ch.out_bike  = out_rec.bike;
  assign out_ch.out_total = out_rec.total;

endmodule

@@ dv/rss_sort_checker.sv @@
// ----------------------------------------------------------------------------
// rss_sort_checker
// Watches both record channels, predicts each sorted burst and compares it.
// ----------------------------------------------------------------------------
// Every accepted record item is stored with its total, or dropped once the
// set is full. A last item runs a selection sort over the stored set and
// queues the burst. Out items are checked field by field against the oldest
// queued entry.
// ----------------------------------------------------------------------------
module rss_sort_checker
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rss_in_if           in_mon,
  rss_out_if          out_mon,
  output int unsigned err_count,
  output int unsigned pending,
  output int unsigned checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rss_rec_t rec;
    logic     last;
    logic     ovf;
  } sorted_item_t;

  rss_rec_t     set_store [MAX_RECORDS];
  int unsigned  set_count;
  logic         set_dropped;
  sorted_item_t sorted_q [$];

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  // selection sort: first strictly smallest total is swapped into place
  function automatic void sort_and_queue();
    int unsigned  pos;
    int unsigned  scan;
    int unsigned  best;
    rss_rec_t     tmp;
    sorted_item_t item;
    for (pos = 0; pos + 1 < set_count; pos++) begin
      best = pos;
      for (scan = pos + 1; scan < set_count; scan++) begin
        if (set_store[best].total > set_store[scan].total) best = scan;
      end
      tmp = set_store[pos];
      set_store[pos] = set_store[best];
      set_store[best] = tmp;
    end
    for (pos = 0; pos < set_count; pos++) begin
      item.rec  = set_store[pos];
      item.last = (pos + 1 == set_count);
      item.ovf  = set_dropped;
      sorted_q.push_back(item);
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    sorted_item_t want;
    rss_rec_t     rec;
    if (!rst_n) begin
      set_count   = 0;
      set_dropped = 1'b0;
      err_count   = 0;
      checked     = 0;
      sorted_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_q.size() == 0) begin
          $error("out item with none expected: id %0h total %0h",
                 out_mon.out_id, out_mon.out_total);
          err_count++;
        end else begin
          want = sorted_q.pop_front();
          checked++;
          check_field("out_id", 17'(want.rec.id), 17'(out_mon.out_id));
          check_field("out_run", 17'(want.rec.run), 17'(out_mon.out_run));
          check_field("out_bike", 17'(want.rec.bike), 17'(out_mon.out_bike));
          check_field("out_total", want.rec.total, out_mon.out_total);
          check_field("out_last", 17'(want.last), 17'(out_mon.out_last));
          check_field("overflow", 17'(want.ovf), 17'(out_mon.overflow));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (set_count < MAX_RECORDS) begin
          rec.id    = in_mon.record_id;
          rec.run   = in_mon.run_score;
          rec.bike  = in_mon.bike_score;
          rec.total = {1'b0, in_mon.run_score} + {1'b0, in_mon.bike_score};
          set_store[set_count] = rec;
          set_count++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_mon.last_record) sort_and_queue();
      end
    end
    pending <= sorted_q.size();
  end

endmodule

@@ dv/tb_record_selection_sorter_top.sv @@
// ----------------------------------------------------------------------------
// tb_record_selection_sorter_top
// Stimulus and verdict for the record selection sorter.
// ----------------------------------------------------------------------------
// Sends a few directed sets (extreme scores, single records, equal totals,
// an oversized set whose last item is dropped), then random sets of mixed
// sizes and score patterns with random gaps on both channels, one long
// output hold-off and three full drains. Checking lives in rss_sort_checker.
// ----------------------------------------------------------------------------
module tb_record_selection_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Cap        = 16;
  localparam int unsigned RandItems  = 300;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 100;

  typedef enum int {SC_FULL, SC_TIES, SC_EDGE} score_mode_t;

  logic        clk;
  logic        rst_n;
  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent;
  int unsigned sets_sent;
  int unsigned ovf_sets;
  bit          tx_fast;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  record_selection_sorter_top #(.MAX_RECORDS(Cap)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rss_sort_checker #(.MAX_RECORDS(Cap)) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .err_count (err_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] pick_score(input score_mode_t mode);
    case (mode)
      SC_TIES: return 16'($urandom_range(0, 3));
      SC_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_record(input logic [15:0] id, input logic [15:0] run,
                             input logic [15:0] bike, input logic last);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.record_id   <= id;
    in_ch.run_score   <= run;
    in_ch.bike_score  <= bike;
    in_ch.last_record <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input int size, input score_mode_t mode);
    int i;
    for (i = 0; i < size; i++) begin
      send_record(16'($urandom_range(0, 65535)), pick_score(mode), pick_score(mode),
                  i == size - 1);
    end
    sets_sent++;
    if (size > Cap) ovf_sets++;
  endtask

  // hold the sender until every queued sorted item has come out
  task automatic wait_sorted_out();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random gaps, stretches with none, one long hold-off
  initial begin : receiver
    int unsigned taken;
    int unsigned gap;
    bit          fast;
    bit          held;
    taken = 0;
    fast  = 1'b0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 24 == 0) fast = ($urandom_range(0, 2) == 0);
      gap = fast ? 0 : $urandom_range(0, 18);
      if (!held && taken == 60) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_record_selection_sorter_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned limit;
    int          size;
    int          roll;
    int          i;
    score_mode_t mode;
    items_sent = 0;
    sets_sent  = 0;
    ovf_sets   = 0;
    tx_fast    = 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.record_id   <= '0;
    in_ch.run_score   <= '0;
    in_ch.bike_score  <= '0;
    in_ch.last_record <= 1'b0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single records at both ends of the score range
    send_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_record(16'h0000, 16'h0000, 16'h0000, 1'b1);
    sets_sent += 2;
    // equal totals: the swaps reorder ties to 3, 2, 1, 4
    send_record(16'd1, 16'd3, 16'd4, 1'b0);
    send_record(16'd2, 16'd7, 16'd0, 1'b0);
    send_record(16'd3, 16'd1, 16'd1, 1'b0);
    send_record(16'd4, 16'd0, 16'd7, 1'b1);
    sets_sent++;
    // full store, then a last item that is dropped but still closes the set
    tx_fast = 1'b1;
    for (i = 0; i < Cap; i++) begin
      send_record(16'(16'h0100 + i), pick_score(SC_FULL), pick_score(SC_EDGE), 1'b0);
    end
    send_record(16'hABCD, 16'h0000, 16'h0000, 1'b1);
    sets_sent++;
    ovf_sets++;
    wait_sorted_out();

    limit = items_sent + RandItems;
    while (items_sent < limit) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) size = 1;
      else if (roll == 1) size = Cap;
      else if (roll == 2) size = $urandom_range(Cap + 1, Cap + 4);
      else size = $urandom_range(2, Cap - 1);
      mode    = score_mode_t'($urandom_range(0, 2));
      tx_fast = ($urandom_range(0, 3) == 0);
      if (sets_sent == 20) wait_sorted_out();
      send_set(size, mode);
    end

    wait_sorted_out();
    repeat (TailCycles) @(posedge clk);
    $display("covered %0d record items in %0d sets, %0d of them oversized",
             items_sent, sets_sent, ovf_sets);
    $display("%0d sorted items compared, %0d mismatches", checked, err_count);
    if (err_count == 0) begin
      $display("tb_record_selection_sorter_top: done, clean");
    end else begin
      $display("tb_record_selection_sorter_top: done, errors");
    end
    $finish;
  end

endmodule
